@@ design/kcl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_pkg
// Types and constants shared by the keypad code lock modules.
// ----------------------------------------------------------------------------
package kcl_pkg;

   localparam int KEY_W     = 8;
   localparam int VALUE_W   = 14;
   localparam int DIGITS_W  = 3;
   localparam int STATUS_W  = 3;
   localparam int WRONG_W   = 3;
   localparam int PHASE_W   = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 14;
   localparam int RSP_W     = 24;

   // Key characters
   localparam logic [KEY_W-1:0] KEY_HASH  = 8'h23;
   localparam logic [KEY_W-1:0] KEY_ZERO  = 8'h30;
   localparam logic [KEY_W-1:0] KEY_NINE  = 8'h39;

   // Session phases
   localparam logic [PHASE_W-1:0] PH_USER    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_SERVICE = 3'd1;
   localparam logic [PHASE_W-1:0] PH_NEW     = 3'd2;
   localparam logic [PHASE_W-1:0] PH_LOCK    = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DONE    = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_ENTER    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_WRONG    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LOCK     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OPEN     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NEWCODE  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_CHANGED  = 3'd5;
   localparam logic [STATUS_W-1:0] ST_FINISHED = 3'd6;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SERVICE_CODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WRONG    = 2'd1;

   // Reset values
   localparam logic [VALUE_W-1:0] USER_CODE_RST    = 14'd2660;
   localparam logic [VALUE_W-1:0] SERVICE_CODE_RST = 14'd123;
   localparam logic [WRONG_W-1:0] MAX_WRONG_RST    = 3'd3;
   localparam logic [WRONG_W-1:0] WRONG_SAT        = 3'd7;
   localparam logic [DIGITS_W-1:0] DIGITS_LIMIT    = 3'd4;

   typedef struct packed {
      logic [PHASE_W-1:0]  phase;
      logic [VALUE_W-1:0]  accum_value;
      logic [DIGITS_W-1:0] digit_count;
      logic                digits_stopped;
      logic [WRONG_W-1:0]  wrong_count;
      logic [VALUE_W-1:0]  user_code;
   } kcl_state_type;

   typedef struct packed {
      logic [DIGITS_W-1:0] digits_entered;
      logic [VALUE_W-1:0]  entry_value;
      logic [STATUS_W-1:0] status;
   } kcl_result_type;

   typedef struct packed {
      logic [VALUE_W-1:0] service_code;
      logic [WRONG_W-1:0] max_wrong;
   } kcl_cfg_type;

endpackage

@@ design/keypad_code_lock.sv @@
`timescale 1ns / 1ps
// Flow: an accepted key beat is held in the input register and passes through kcl_step
//    into the result register once that register is empty or its beat is being taken.
// Throughput: one key per cycle while rsp_tready is high; the whole step is one pass
//    of kcl_step between the input register and the result register.
// Reset: synchronous, active high; clears both stages, the session state
//    (user code back to 2660) and the configuration registers.
// ----------------------------------------------------------------------------
// keypad_code_lock
// Keypad code lock: builds entries from key presses, checks the user and
// service codes, changes the user code and locks out after wrong attempts.
// ----------------------------------------------------------------------------
module keypad_code_lock #(
   parameter int MAX_KEYS   = 5,
   parameter int MAX_DIGITS = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   // Key stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] key
   // Result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [kcl_pkg::RSP_W-1:0]      rsp_tdata,   // [2:0] status, [16:3] entry_value,
                                                       // [19:17] digits_entered, [23:20] zero
   // Configuration writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [kcl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kcl_pkg::CSR_DAT_W-1:0]  csr_data
);
   import kcl_pkg::*;

   localparam int KEY_CNT_W = $clog2(MAX_KEYS + 1);

   kcl_cfg_type           cfg;

   // Input stage
   logic                  in_valid_ff, in_valid_in;
   logic [KEY_W-1:0]      in_key_ff, in_key_in;

   // Session state
   kcl_state_type         state_ff, state_in, state_nxt;
   logic [KEY_CNT_W-1:0]  key_count_ff, key_count_in, key_count_nxt;

   // Result stage
   logic                  rsp_valid_ff, rsp_valid_in;
   kcl_result_type        rsp_data_ff, rsp_data_in, step_result;

   logic                  advance;
   logic                  req_take;

   kcl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   kcl_step #(
      .MAX_KEYS   (MAX_KEYS),
      .MAX_DIGITS (MAX_DIGITS),
      .KEY_CNT_W  (KEY_CNT_W)
   ) u_step (
      .key           (in_key_ff),
      .state_cur     (state_ff),
      .key_count_cur (key_count_ff),
      .cfg           (cfg),
      .state_nxt     (state_nxt),
      .key_count_nxt (key_count_nxt),
      .result        (step_result)
   );

   // Advance the held key into the result register when that register frees up;
   // the input stage takes a new beat even while a result waits downstream.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_key_in    = in_key_ff;
      state_in     = state_ff;
      key_count_in = key_count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Commit the step: session state and result move together
      if (advance) begin
         state_in     = state_nxt;
         key_count_in = key_count_nxt;
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_result;
         in_valid_in  = 1'b0;
      end

      // Hold a newly accepted key
      if (req_take) begin
         in_valid_in = 1'b1;
         in_key_in   = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff              <= 1'b0;
         rsp_valid_ff             <= 1'b0;
         state_ff.phase           <= PH_USER;
         state_ff.accum_value     <= '0;
         state_ff.digit_count     <= '0;
         state_ff.digits_stopped  <= 1'b0;
         state_ff.wrong_count     <= '0;
         state_ff.user_code       <= USER_CODE_RST;
         key_count_ff             <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         key_count_ff <= key_count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_key_ff   <= in_key_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - $bits(kcl_result_type)){1'b0}}, rsp_data_ff};

endmodule

@@ design/kcl_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_csr
// Configuration registers: service code and wrong-attempt limit.
// ----------------------------------------------------------------------------
module kcl_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [kcl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kcl_pkg::CSR_DAT_W-1:0]  csr_data,
   output kcl_pkg::kcl_cfg_type           cfg
);
   import kcl_pkg::*;

   logic [VALUE_W-1:0] service_code_ff, service_code_in;
   logic [WRONG_W-1:0] max_wrong_ff, max_wrong_in;

   assign csr_ready = 1'b1;

   always_comb begin
      service_code_in = service_code_ff;
      max_wrong_in    = max_wrong_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SERVICE_CODE: service_code_in = csr_data[VALUE_W-1:0];
            CSR_MAX_WRONG:    max_wrong_in    = csr_data[WRONG_W-1:0];
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         service_code_ff <= SERVICE_CODE_RST;
         max_wrong_ff    <= MAX_WRONG_RST;
      end else begin
         service_code_ff <= service_code_in;
         max_wrong_ff    <= max_wrong_in;
      end
   end

   assign cfg.service_code = service_code_ff;
   assign cfg.max_wrong    = max_wrong_ff;

endmodule

@@ design/kcl_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_step
// Next-state and result logic for one key press.
// ----------------------------------------------------------------------------
module kcl_step #(
   parameter int MAX_KEYS   = 5,
   parameter int MAX_DIGITS = 4,
   parameter int KEY_CNT_W  = $clog2(MAX_KEYS + 1)
) (
   input  logic [kcl_pkg::KEY_W-1:0]  key,
   input  kcl_pkg::kcl_state_type     state_cur,
   input  logic [KEY_CNT_W-1:0]       key_count_cur,
   input  kcl_pkg::kcl_cfg_type       cfg,
   output kcl_pkg::kcl_state_type     state_nxt,
   output logic [KEY_CNT_W-1:0]       key_count_nxt,
   output kcl_pkg::kcl_result_type    result
);
   import kcl_pkg::*;

   logic                  is_hash;
   logic                  is_digit;
   logic                  done;
   logic [VALUE_W+3:0]    acc_wide;
   logic [VALUE_W-1:0]    acc;
   logic [DIGITS_W-1:0]   dc;
   logic                  stop;
   logic [KEY_CNT_W-1:0]  kc;
   logic [WRONG_W-1:0]    wc;

   always_comb begin
      state_nxt     = state_cur;
      key_count_nxt = key_count_cur;
      result        = '0;
      is_hash       = (key == KEY_HASH);
      is_digit      = key inside {[KEY_ZERO:KEY_NINE]};
      acc           = state_cur.accum_value;
      dc            = state_cur.digit_count;
      stop          = state_cur.digits_stopped;
      kc            = key_count_cur;
      done          = 1'b0;
      acc_wide      = '0;
      wc            = state_cur.wrong_count;

      if (state_cur.phase == PH_LOCK || state_cur.phase == PH_DONE) begin
         // Terminal: ignore the key
         result.status = (state_cur.phase == PH_LOCK) ? ST_LOCK : ST_FINISHED;
      end else begin
         if (is_hash) begin
            done = 1'b1;
         end else begin
            if (is_digit) begin
               if (!stop && dc < DIGITS_W'(MAX_DIGITS)) begin
                  // acc * 10 + digit
                  acc_wide = ({4'd0, acc} << 3) + ({4'd0, acc} << 1)
                             + {{(VALUE_W){1'b0}}, key[3:0]};
                  acc = acc_wide[VALUE_W-1:0];
                  dc  = dc + 1'b1;
               end
            end else begin
               stop = 1'b1;
            end
            kc = kc + 1'b1;
            if (kc >= KEY_CNT_W'(MAX_KEYS)) begin
               done = 1'b1;
            end
         end

         result.entry_value    = acc;
         result.digits_entered = dc;

         if (!done) begin
            case (state_cur.phase)
               PH_SERVICE: result.status = ST_OPEN;
               PH_NEW:     result.status = ST_NEWCODE;
               default:    result.status = ST_ENTER;
            endcase
            state_nxt.accum_value    = acc;
            state_nxt.digit_count    = dc;
            state_nxt.digits_stopped = stop;
            key_count_nxt            = kc;
         end else begin
            case (state_cur.phase)
               PH_USER: begin
                  if (acc == state_cur.user_code) begin
                     state_nxt.wrong_count = '0;
                     state_nxt.phase       = PH_SERVICE;
                     result.status         = ST_OPEN;
                  end else begin
                     if (wc < WRONG_SAT) begin
                        wc = wc + 1'b1;
                     end
                     state_nxt.wrong_count = wc;
                     if (wc >= cfg.max_wrong) begin
                        state_nxt.phase = PH_LOCK;
                        result.status   = ST_LOCK;
                     end else begin
                        result.status   = ST_WRONG;
                     end
                  end
               end
               PH_SERVICE: begin
                  if (acc == cfg.service_code) begin
                     state_nxt.phase = PH_NEW;
                     result.status   = ST_NEWCODE;
                  end else begin
                     state_nxt.phase = PH_DONE;
                     result.status   = ST_FINISHED;
                  end
               end
               default: begin
                  state_nxt.user_code = acc;
                  state_nxt.phase     = PH_USER;
                  result.status       = ST_CHANGED;
               end
            endcase
            // Clear the entry buffers for the next entry
            state_nxt.accum_value    = '0;
            state_nxt.digit_count    = '0;
            state_nxt.digits_stopped = 1'b0;
            key_count_nxt            = '0;
         end
      end
   end

endmodule

@@ design/kcl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_checker
// Port-level checks on the keypad code lock, bound to the top level.
// ----------------------------------------------------------------------------
module kcl_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [kcl_pkg::RSP_W-1:0]  rsp_tdata
);
   import kcl_pkg::*;

   // Stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // Nothing comes out straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // With the output side empty the key side must be open
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("key side stalled with empty result stage");

   // Zero fill stays clear and the entry value fits in four digits
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_W-1:20] == '0 && rsp_tdata[16:3] <= 14'd9999)
      else $error("result fill or entry value out of range");

   // Digit count within limit and status a known code
   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[19:17] <= DIGITS_LIMIT && rsp_tdata[2:0] <= ST_FINISHED)
      else $error("result field out of range");

endmodule

bind keypad_code_lock kcl_checker u_kcl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ verif/keypad_code_lock_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_code_lock_tb
// Self-checking bench for the keypad code lock. A short table of key presses
// walks the entry rules and one full session. Random user, service and
// new-code entries then run under several register settings, with random
// stalls on both streams. Every result beat is checked against a model of
// the lock that the bench keeps itself, or against the hand-typed result of a pinned row.
// ----------------------------------------------------------------------------
module keypad_code_lock_tb;
   import kcl_pkg::*;

   localparam int ENTRY_KEYS   = 5;
   localparam int ENTRY_DIGITS = 4;
   localparam int DRAIN_CYCLES = 8;
   localparam int TIMEOUT_NS   = 2_000_000;
   localparam int TABLE_ROWS   = 24;

   // Index with no register behind it; writes to it must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   // One directed key press; pinned rows carry a result typed in by hand
   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic                pinned;
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  value;
      logic [DIGITS_W-1:0] digits;
   } key_row_type;

   // Runs with the reset settings: service code 123, three tries, code 2660
   localparam key_row_type KEY_TABLE [TABLE_ROWS] = '{
      // lowest key is no digit: it halts digit capture, entry stays open
      '{8'h00,    1'b1, ST_ENTER,    14'd0,    3'd0},
      // empty entry closed by the hash key: first wrong try
      '{KEY_HASH, 1'b1, ST_WRONG,    14'd0,    3'd0},
      '{KEY_NINE, 1'b0, ST_ENTER,    14'd0,    3'd0},
      '{KEY_NINE, 1'b0, ST_ENTER,    14'd0,    3'd0},
      '{KEY_NINE, 1'b0, ST_ENTER,    14'd0,    3'd0},
      // largest value the entry can hold
      '{KEY_NINE, 1'b1, ST_ENTER,    14'd9999, 3'd4},
      // fifth digit is dropped, fifth key closes the entry: second wrong try
      '{KEY_ZERO, 1'b1, ST_WRONG,    14'd9999, 3'd4},
      '{8'h32,    1'b0, ST_ENTER,    14'd0,    3'd0},
      '{8'h36,    1'b0, ST_ENTER,    14'd0,    3'd0},
      '{8'h36,    1'b0, ST_ENTER,    14'd0,    3'd0},
      '{KEY_ZERO, 1'b0, ST_ENTER,    14'd0,    3'd0},
      // key just below the digits closes on key count; match clears tries
      '{8'h2F,    1'b1, ST_OPEN,     14'd2660, 3'd4},
      '{8'h31,    1'b0, ST_ENTER,    14'd0,    3'd0},
      '{8'h32,    1'b0, ST_ENTER,    14'd0,    3'd0},
      '{8'h33,    1'b0, ST_ENTER,    14'd0,    3'd0},
      // key just above the digits halts capture
      '{8'h3A,    1'b0, ST_ENTER,    14'd0,    3'd0},
      '{KEY_HASH, 1'b1, ST_NEWCODE,  14'd123,  3'd3},
      '{KEY_ZERO, 1'b0, ST_ENTER,    14'd0,    3'd0},
      '{8'h35,    1'b0, ST_ENTER,    14'd0,    3'd0},
      // highest key halts capture
      '{8'hFF,    1'b0, ST_ENTER,    14'd0,    3'd0},
      '{KEY_HASH, 1'b1, ST_CHANGED,  14'd5,    3'd2},
      '{KEY_HASH, 1'b1, ST_WRONG,    14'd0,    3'd0},
      '{8'h35,    1'b0, ST_ENTER,    14'd0,    3'd0},
      '{KEY_HASH, 1'b1, ST_OPEN,     14'd5,    3'd1}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [KEY_W-1:0]     req_tdata;      // [7:0] key
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_W-1:0]     rsp_tdata;      // [2:0] status, [16:3] entry_value,
                                         // [19:17] digits_entered, [23:20] zero
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   // Lock model state, stepped at every accepted key beat
   logic [PHASE_W-1:0]   lock_phase    = PH_USER;
   logic [VALUE_W-1:0]   entry_accum   = '0;
   logic [DIGITS_W-1:0]  entry_digits  = '0;
   int                   entry_keys    = 0;
   logic                 digits_halted = 1'b0;
   logic [WRONG_W-1:0]   wrong_tries   = '0;
   logic [VALUE_W-1:0]   user_code     = USER_CODE_RST;
   logic [VALUE_W-1:0]   service_code  = SERVICE_CODE_RST;
   logic [WRONG_W-1:0]   max_wrong     = MAX_WRONG_RST;
   logic                 entry_closed  = 1'b0;

   kcl_result_type       pending_results [$];
   logic                 pin_valid     = 1'b0;
   kcl_result_type       pin_result    = '0;
   logic                 steady        = 1'b0;
   int                   keys_sent     = 0;
   int                   results_seen  = 0;
   int                   mismatches    = 0;
   string                ending        = "code entry";

   keypad_code_lock #(
      .MAX_KEYS   (ENTRY_KEYS),
      .MAX_DIGITS (ENTRY_DIGITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Advance the lock by one key press and return the result it gives
   function automatic kcl_result_type lock_step(input logic [KEY_W-1:0] key);
      kcl_result_type r;
      int             sum;
      logic           done;
      r            = '0;
      done         = 1'b0;
      entry_closed = 1'b0;
      // terminal phases ignore keys until reset
      if (lock_phase == PH_LOCK || lock_phase == PH_DONE) begin
         r.status = (lock_phase == PH_LOCK) ? ST_LOCK : ST_FINISHED;
         return r;
      end
      if (key == KEY_HASH) begin
         done = 1'b1;
      end else begin
         if (key >= KEY_ZERO && key <= KEY_NINE) begin
            if (!digits_halted && entry_digits < DIGITS_LIMIT) begin
               sum          = int'(entry_accum) * 10 + int'(key - KEY_ZERO);
               entry_accum  = sum[VALUE_W-1:0];
               entry_digits = entry_digits + 1'b1;
            end
         end else begin
            digits_halted = 1'b1;
         end
         entry_keys++;
         if (entry_keys >= ENTRY_KEYS) done = 1'b1;
      end
      r.entry_value    = entry_accum;
      r.digits_entered = entry_digits;
      if (!done) begin
         if (lock_phase == PH_SERVICE) r.status = ST_OPEN;
         else if (lock_phase == PH_NEW) r.status = ST_NEWCODE;
         else r.status = ST_ENTER;
         return r;
      end
      case (lock_phase)
         PH_USER: begin
            if (entry_accum == user_code) begin
               wrong_tries = '0;
               lock_phase  = PH_SERVICE;
               r.status    = ST_OPEN;
            end else begin
               // tries saturate; a limit of zero locks on the first miss
               if (wrong_tries < WRONG_SAT) wrong_tries = wrong_tries + 1'b1;
               if (wrong_tries >= max_wrong) begin
                  lock_phase = PH_LOCK;
                  r.status   = ST_LOCK;
               end else begin
                  r.status   = ST_WRONG;
               end
            end
         end
         PH_SERVICE: begin
            if (entry_accum == service_code) begin
               lock_phase = PH_NEW;
               r.status   = ST_NEWCODE;
            end else begin
               lock_phase = PH_DONE;
               r.status   = ST_FINISHED;
            end
         end
         default: begin
            user_code  = entry_accum;
            lock_phase = PH_USER;
            r.status   = ST_CHANGED;
         end
      endcase
      entry_accum   = '0;
      entry_digits  = '0;
      entry_keys    = 0;
      digits_halted = 1'b0;
      entry_closed  = 1'b1;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                              input logic [VALUE_W-1:0] seen);
      if (seen !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
         mismatches++;
      end
   endtask

   // Check result beats against the oldest expectation, then log new key
   // beats and register writes into the model, all at the same edge
   always @(posedge clock) begin : scoreboard
      kcl_result_type seen;
      kcl_result_type want;
      kcl_result_type predicted;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            seen = rsp_tdata[$bits(kcl_result_type)-1:0];
            if (pending_results.size() == 0) begin
               $display("%0t ns: result beat with none expected, actual status %0d value %0d digits %0d",
                        $time, seen.status, seen.entry_value, seen.digits_entered);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("status", VALUE_W'(want.status), VALUE_W'(seen.status));
               check_field("entry_value", want.entry_value, seen.entry_value);
               check_field("digits_entered", VALUE_W'(want.digits_entered),
                           VALUE_W'(seen.digits_entered));
               check_field("zero fill", '0, VALUE_W'(rsp_tdata[RSP_W-1:$bits(kcl_result_type)]));
            end
         end
         if (req_tvalid && req_tready) begin
            predicted = lock_step(req_tdata);
            pending_results.push_back(pin_valid ? pin_result : predicted);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SERVICE_CODE: service_code = csr_data;
               CSR_MAX_WRONG:    max_wrong    = csr_data[WRONG_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Result side: stall about one cycle in ten, never while steady is set
   initial begin : rsp_side
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= steady || ($urandom_range(0, 99) >= 10);
      end
   end

   // Enter and leave at a falling edge; valid stays high when no gap follows
   task automatic send_key(input logic [KEY_W-1:0] key, input logic pin = 1'b0,
                           input kcl_result_type pinned = '0);
      pin_valid  = pin;
      pin_result = pinned;
      while (!steady && $urandom_range(0, 99) < 10) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      keys_sent++;
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] addr, input int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= addr;
      csr_data  <= CSR_DAT_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drop valid and hold off until every expected result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_and_configure(input int svc, input int tries);
      drain_results();
      csr_write(CSR_SERVICE_CODE, svc);
      // upper data bits are junk and must be dropped by the register
      csr_write(CSR_MAX_WRONG, int'($urandom_range(0, 2047) << WRONG_W) | tries);
   endtask

   function automatic logic [KEY_W-1:0] filler_key();
      logic [KEY_W-1:0] k;
      do k = KEY_W'($urandom_range(0, 255));
      while ((k >= KEY_ZERO && k <= KEY_NINE) || k == KEY_HASH);
      return k;
   endfunction

   function automatic logic [KEY_W-1:0] rand_key();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return KEY_ZERO + KEY_W'($urandom_range(0, 9));
         4:          return KEY_HASH;
         default:    return KEY_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int wrong_value();
      int v;
      v = $urandom_range(0, 9999);
      if (v == int'(user_code)) v = (v + 1) % 10000;
      return v;
   endfunction

   // Well-formed entry of value v: optional leading zeros, then a random
   // tail of junk keys or ignored digits, closed by hash or by key count
   task automatic send_entry(input int v);
      int   pw [ENTRY_DIGITS] = '{1, 10, 100, 1000};
      int   len;
      int   typed;
      int   p;
      logic halted;
      len = (v >= 1000) ? 4 : (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
      len = $urandom_range(len, ENTRY_DIGITS);
      for (p = len - 1; p >= 0; p--) send_key(KEY_ZERO + KEY_W'((v / pw[p]) % 10));
      halted = 1'b0;
      typed  = len;
      while (typed < ENTRY_KEYS) begin
         if ($urandom_range(0, 1) == 1) begin
            send_key(KEY_HASH);
            break;
         end
         if ((halted || len == ENTRY_DIGITS) && $urandom_range(0, 1) == 1) begin
            send_key(KEY_ZERO + KEY_W'($urandom_range(0, 9)));
         end else begin
            send_key(filler_key());
            halted = 1'b1;
         end
         typed++;
      end
   endtask

   task automatic noise_entry();
      do send_key(rand_key());
      while (!entry_closed);
   endtask

   // Pick the next entry from the model's phase; never end the session
   task automatic next_entry();
      int pick;
      pick = $urandom_range(0, 7);
      case (lock_phase)
         PH_USER: begin
            if (int'(wrong_tries) + 1 < int'(max_wrong) && pick < 3) begin
               if (pick == 0) noise_entry();
               else send_entry(wrong_value());
            end else begin
               send_entry(int'(user_code));
            end
         end
         PH_SERVICE: send_entry(int'(service_code));
         default: begin
            if (pick < 2) noise_entry();
            else if (pick == 2) send_entry(0);
            else if (pick == 3) send_entry(9999);
            else send_entry($urandom_range(0, 9999));
         end
      endcase
   endtask

   task automatic run_entries(input int count);
      int stop_at;
      stop_at = keys_sent + count;
      while (keys_sent < stop_at) next_entry();
   endtask

   initial begin : key_source
      key_row_type    row;
      kcl_result_type typed_in;
      int             i;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_SERVICE_CODE;
      csr_data   = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed walk through one whole session on the reset settings
      for (i = 0; i < TABLE_ROWS; i++) begin
         row                     = KEY_TABLE[i];
         typed_in.status         = row.status;
         typed_in.entry_value    = row.value;
         typed_in.digits_entered = row.digits;
         send_key(row.key, row.pinned, typed_in);
      end

      // largest valid service code, most tries
      drain_and_configure(9999, int'(WRONG_SAT));
      run_entries(300);

      // smallest service code and a single try; no stalls on either side
      steady = 1'b1;
      drain_and_configure(0, 1);
      run_entries(200);
      steady = 1'b0;

      drain_and_configure($urandom_range(1, 9998), $urandom_range(2, 6));
      csr_write(CSR_UNMAPPED, $urandom_range(0, 16383));
      run_entries(300);

      drain_and_configure($urandom_range(0, 9999), $urandom_range(1, 7));
      run_entries(300);

      // end the session in one of its two terminal phases
      while (lock_phase != PH_USER) next_entry();
      drain_results();
      if ($urandom_range(0, 1) == 1) begin
         ending = "lockout on a zero try limit";
         csr_write(CSR_MAX_WRONG, int'($urandom_range(0, 2047) << WRONG_W));
         send_entry(wrong_value());
      end else begin
         ending = "finished on an unmatchable service code";
         csr_write(CSR_SERVICE_CODE, $urandom_range(10000, 16383));
         send_entry(int'(user_code));
         send_entry($urandom_range(0, 9999));
      end
      for (i = 0; i < 16; i++) send_key(KEY_W'($urandom_range(0, 255)));

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d key beats, checked %0d result beats across five register settings.",
               keys_sent, results_seen);
      $display("Session closed in %s; %0d mismatches logged.", ending, mismatches);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ files.f @@
design/kcl_pkg.sv
design/kcl_csr.sv
design/kcl_step.sv
design/keypad_code_lock.sv
design/kcl_checker.sv
verif/keypad_code_lock_tb.sv
